@@ sv/led_twinkle_fade_engine_defines.svh @@
// Assertion macros used by the checker of the fade engine.
`ifndef LED_TWINKLE_FADE_ENGINE_DEFINES_SVH
`define LED_TWINKLE_FADE_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LTFE_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LTFE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/ltfe_pkg.sv @@
package ltfe_pkg;

  localparam int CELL_COUNT   = 16;
  localparam int PALETTE_SIZE = 10;
  localparam int FADE_STEPS   = 15;

  localparam int IDX_W   = 4;
  localparam int CNT_W   = $clog2(CELL_COUNT + 1);
  localparam int STEP_W  = 5;
  localparam int HOLD_W  = 6;
  localparam int COLOR_W = 4;
  localparam int CD_W    = 5;
  localparam int CFG_W   = 5;
  localparam int CHAN_W  = 8;

  localparam int HOLD_MIN    = 15;
  localparam int HOLD_MAX    = 60;
  localparam int CD_MIN      = 5;
  localparam int CD_MAX      = 20;
  localparam int MAX_ACT_RST = 6;

  localparam logic [1:0] PH_OFF  = 2'd0;
  localparam logic [1:0] PH_IN   = 2'd1;
  localparam logic [1:0] PH_HOLD = 2'd2;
  localparam logic [1:0] PH_OUT  = 2'd3;

  // Division by FADE_STEPS is a multiply by a rounded-up reciprocal. The
  // overshoot stays below 1/FADE_STEPS for every product, so the floor is exact.
  localparam int PROD_W    = CHAN_W + STEP_W;
  localparam int DIV_SHIFT = PROD_W + STEP_W;
  localparam int DIV_MUL   = (1 << DIV_SHIFT) / FADE_STEPS + 1;
  localparam int MUL_W     = $clog2(DIV_MUL + 1);
  localparam int FULL_W    = PROD_W + MUL_W;

  typedef struct packed {
    logic [1:0]         phase;
    logic [STEP_W-1:0]  step;
    logic [HOLD_W-1:0]  hold;
    logic [COLOR_W-1:0] color;
  } cell_t;

  typedef struct packed {
    logic               clear;
    logic               spawn;
    logic [COLOR_W-1:0] color;
    logic [HOLD_W-1:0]  hold;
  } upd_ctrl_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [STEP_W-1:0]  level;
    logic [IDX_W-1:0]   index;
    logic               last;
  } pix_req_t;

  // Palette as {red, green, blue}; unused indexes are black.
  function automatic logic [3*CHAN_W-1:0] palette_rgb(input logic [COLOR_W-1:0] idx);
    logic [3*CHAN_W-1:0] rgb;
    case (idx)
      4'd0:    rgb = 24'hFF0000;
      4'd1:    rgb = 24'hA0141E;
      4'd2:    rgb = 24'h0AE61E;
      4'd3:    rgb = 24'h0032FF;
      4'd4:    rgb = 24'hDCC800;
      4'd5:    rgb = 24'hFFFFFF;
      4'd6:    rgb = 24'hB400B4;
      4'd7:    rgb = 24'hFF5000;
      4'd8:    rgb = 24'h0A64C8;
      4'd9:    rgb = 24'h96C800;
      default: rgb = '0;
    endcase
    return rgb;
  endfunction

endpackage

@@ sv/led_twinkle_fade_engine.sv @@
// After a request is accepted, each pixel passes the product register and then the output register of the shade unit.
// Each request yields 16 pixels, one per cycle while the output is taken.
// A new request is accepted only after all 16 cells have passed the head of the ring,
// as the one shared update unit serves the cells in turn.
// Reset (async, active low): all cells off, cooldown zero, cap of lit cells six.
module led_twinkle_fade_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // free_pick[3:0], palette_pick[7:4], hold_pick[13:8], cooldown_pick[18:14]
  input  logic [23:0]                 s_axis_tdata,
  // command[0]
  input  logic [0:0]                  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // pixel_index[3:0], red[11:4], green[19:12], blue[27:20]
  output logic [31:0]                 m_axis_tdata,
  output logic                        m_axis_tlast,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ltfe_pkg::CFG_W-1:0]  cfg_data_i
);

  localparam int CMP_W = ltfe_pkg::CNT_W + 8;

  logic                            busy_q;
  logic                            restart_q;
  logic                            spawn_q;
  logic [ltfe_pkg::CNT_W-1:0]      pick_q;
  logic [ltfe_pkg::CNT_W-1:0]      seen_q;
  logic [ltfe_pkg::CNT_W-1:0]      acc_q;
  logic [ltfe_pkg::CNT_W-1:0]      active_q;
  logic [ltfe_pkg::IDX_W-1:0]      cnt_q;
  logic [ltfe_pkg::COLOR_W-1:0]    color_q;
  logic [ltfe_pkg::COLOR_W-1:0]    color_d;
  logic [ltfe_pkg::HOLD_W-1:0]     hold_q;
  logic [ltfe_pkg::HOLD_W-1:0]     hold_d;
  logic [ltfe_pkg::CD_W-1:0]       cooldown_q;
  logic [ltfe_pkg::CD_W-1:0]       cooldown_d;
  logic [ltfe_pkg::CD_W-1:0]       cd_pick;
  logic [ltfe_pkg::CFG_W-1:0]      max_active_q;

  logic                            accept;
  logic                            issue;
  logic                            adv;
  logic                            command;
  logic [3:0]                      free_pick;
  logic [3:0]                      palette_pick;
  logic [5:0]                      hold_pick;
  logic [4:0]                      cooldown_pick;
  logic [CMP_W-1:0]                free_cnt;
  logic [CMP_W-1:0]                pick_ext;
  logic [ltfe_pkg::CNT_W-1:0]      pick_d;
  logic                            spawn_ok;

  ltfe_pkg::cell_t                 chain [ltfe_pkg::CELL_COUNT];
  ltfe_pkg::cell_t                 head_next;
  ltfe_pkg::upd_ctrl_t             ctrl;
  ltfe_pkg::pix_req_t              req;
  logic [ltfe_pkg::STEP_W-1:0]     level;
  logic                            head_active;

  assign s_axis_tready = !busy_q;
  assign cfg_ready_o   = 1'b1;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign issue         = busy_q && adv;

  assign command       = s_axis_tuser[0];
  assign free_pick     = s_axis_tdata[3:0];
  assign palette_pick  = s_axis_tdata[7:4];
  assign hold_pick     = s_axis_tdata[13:8];
  assign cooldown_pick = s_axis_tdata[18:14];

  // Spawn decision and the picks are settled when the request is accepted.
  always_comb begin
    free_cnt = CMP_W'(ltfe_pkg::CELL_COUNT) - CMP_W'(active_q);
    pick_ext = CMP_W'(free_pick);
    spawn_ok = (cooldown_q == '0)
            && (CMP_W'(active_q) < CMP_W'(ltfe_pkg::CELL_COUNT))
            && (CMP_W'(active_q) < CMP_W'(max_active_q));
    if (pick_ext > free_cnt - CMP_W'(1)) begin
      pick_d = ltfe_pkg::CNT_W'(free_cnt - CMP_W'(1));
    end else begin
      pick_d = ltfe_pkg::CNT_W'(pick_ext);
    end

    if (palette_pick > 4'(ltfe_pkg::PALETTE_SIZE - 1)) begin
      color_d = ltfe_pkg::COLOR_W'(ltfe_pkg::PALETTE_SIZE - 1);
    end else begin
      color_d = ltfe_pkg::COLOR_W'(palette_pick);
    end

    if (hold_pick < 6'(ltfe_pkg::HOLD_MIN)) begin
      hold_d = ltfe_pkg::HOLD_W'(ltfe_pkg::HOLD_MIN);
    end else if (hold_pick > 6'(ltfe_pkg::HOLD_MAX)) begin
      hold_d = ltfe_pkg::HOLD_W'(ltfe_pkg::HOLD_MAX);
    end else begin
      hold_d = ltfe_pkg::HOLD_W'(hold_pick);
    end

    if (cooldown_pick < 5'(ltfe_pkg::CD_MIN)) begin
      cd_pick = ltfe_pkg::CD_W'(ltfe_pkg::CD_MIN);
    end else if (cooldown_pick > 5'(ltfe_pkg::CD_MAX)) begin
      cd_pick = ltfe_pkg::CD_W'(ltfe_pkg::CD_MAX);
    end else begin
      cd_pick = ltfe_pkg::CD_W'(cooldown_pick);
    end

    // The cooldown is loaded by a spawn and then drops by one in the same tick.
    if (command) begin
      cooldown_d = '0;
    end else if (cooldown_q == '0) begin
      cooldown_d = spawn_ok ? cd_pick - ltfe_pkg::CD_W'(1) : '0;
    end else begin
      cooldown_d = cooldown_q - ltfe_pkg::CD_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      restart_q    <= 1'b0;
      spawn_q      <= 1'b0;
      pick_q       <= '0;
      seen_q       <= '0;
      acc_q        <= '0;
      active_q     <= '0;
      cnt_q        <= '0;
      cooldown_q   <= '0;
      max_active_q <= ltfe_pkg::CFG_W'(ltfe_pkg::MAX_ACT_RST);
    end else begin
      if (cfg_valid_i) begin
        max_active_q <= cfg_data_i;
      end
      if (accept) begin
        busy_q     <= 1'b1;
        restart_q  <= command;
        spawn_q    <= !command && spawn_ok;
        pick_q     <= pick_d;
        seen_q     <= '0;
        acc_q      <= '0;
        cnt_q      <= '0;
        cooldown_q <= cooldown_d;
      end else if (issue) begin
        seen_q <= seen_q + ltfe_pkg::CNT_W'(chain[0].phase == ltfe_pkg::PH_OFF);
        acc_q  <= acc_q + ltfe_pkg::CNT_W'(head_active);
        cnt_q  <= cnt_q + ltfe_pkg::IDX_W'(1);
        if (cnt_q == ltfe_pkg::IDX_W'(ltfe_pkg::CELL_COUNT - 1)) begin
          busy_q   <= 1'b0;
          active_q <= acc_q + ltfe_pkg::CNT_W'(head_active);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      color_q <= color_d;
      hold_q  <= hold_d;
    end
  end

  // The ring turns once per pixel; after a full frame every cell is back in place.
  for (genvar k = 0; k < ltfe_pkg::CELL_COUNT; k++) begin : g_cell
    ltfe_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (issue),
      .cell_i  ((k == ltfe_pkg::CELL_COUNT - 1) ? head_next : chain[(k + 1) % ltfe_pkg::CELL_COUNT]),
      .cell_o  (chain[k])
    );
  end

  always_comb begin
    ctrl.clear = restart_q;
    ctrl.spawn = spawn_q && (chain[0].phase == ltfe_pkg::PH_OFF) && (seen_q == pick_q);
    ctrl.color = color_q;
    ctrl.hold  = hold_q;
  end

  ltfe_update u_update (
    .cell_i   (chain[0]),
    .ctrl_i   (ctrl),
    .cell_o   (head_next),
    .level_o  (level),
    .active_o (head_active)
  );

  always_comb begin
    req.color = head_next.color;
    req.level = level;
    req.index = cnt_q;
    req.last  = (cnt_q == ltfe_pkg::IDX_W'(ltfe_pkg::CELL_COUNT - 1));
  end

  ltfe_shade u_shade (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (busy_q),
    .req_i       (req),
    .adv_o       (adv),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast)
  );

endmodule

@@ sv/ltfe_cell.sv @@
module ltfe_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  ltfe_pkg::cell_t cell_i,
  output ltfe_pkg::cell_t cell_o
);

  ltfe_pkg::cell_t cell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (shift_i) begin
      cell_q <= cell_i;
    end
  end

  assign cell_o = cell_q;

endmodule

@@ sv/ltfe_update.sv @@
module ltfe_update (
  input  ltfe_pkg::cell_t                  cell_i,
  input  ltfe_pkg::upd_ctrl_t              ctrl_i,
  output ltfe_pkg::cell_t                  cell_o,
  output logic [ltfe_pkg::STEP_W-1:0]      level_o,
  output logic                             active_o
);

  ltfe_pkg::cell_t             cur;
  ltfe_pkg::cell_t             nxt;
  logic [ltfe_pkg::STEP_W:0]   inc;

  always_comb begin
    cur = cell_i;
    if (ctrl_i.spawn) begin
      cur.phase = ltfe_pkg::PH_IN;
      cur.step  = '0;
      cur.color = ctrl_i.color;
      cur.hold  = ctrl_i.hold;
    end
    nxt = cur;
    inc = {1'b0, cur.step} + (ltfe_pkg::STEP_W+1)'(1);
    case (cur.phase)
      ltfe_pkg::PH_IN: begin
        if (inc > (ltfe_pkg::STEP_W+1)'(ltfe_pkg::FADE_STEPS)) begin
          nxt.phase = ltfe_pkg::PH_HOLD;
          nxt.step  = '0;
        end else begin
          nxt.step = inc[ltfe_pkg::STEP_W-1:0];
        end
      end
      ltfe_pkg::PH_HOLD: begin
        if (cur.hold <= ltfe_pkg::HOLD_W'(1)) begin
          nxt.phase = ltfe_pkg::PH_OUT;
          nxt.step  = ltfe_pkg::STEP_W'(ltfe_pkg::FADE_STEPS);
        end else begin
          nxt.hold = cur.hold - ltfe_pkg::HOLD_W'(1);
        end
      end
      ltfe_pkg::PH_OUT: begin
        if (cur.step == '0) begin
          nxt.phase = ltfe_pkg::PH_OFF;
        end else begin
          nxt.step = cur.step - ltfe_pkg::STEP_W'(1);
        end
      end
      default: begin
      end
    endcase
    if (ctrl_i.clear) begin
      nxt = '0;
    end
  end

  // A held cell shows its full color, which is a fade at the top step.
  always_comb begin
    case (nxt.phase)
      ltfe_pkg::PH_OFF:  level_o = '0;
      ltfe_pkg::PH_HOLD: level_o = ltfe_pkg::STEP_W'(ltfe_pkg::FADE_STEPS);
      default:           level_o = nxt.step;
    endcase
  end

  assign cell_o   = nxt;
  assign active_o = (nxt.phase != ltfe_pkg::PH_OFF);

endmodule

@@ sv/ltfe_shade.sv @@
module ltfe_shade (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  ltfe_pkg::pix_req_t req_i,
  output logic               adv_o,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output logic [31:0]        m_data_o,
  output logic               m_last_o
);

  logic                             p1_valid_q;
  logic [ltfe_pkg::PROD_W-1:0]      p1_prod_q [3];
  logic [ltfe_pkg::PROD_W-1:0]      p1_prod_d [3];
  logic [ltfe_pkg::IDX_W-1:0]       p1_index_q;
  logic                             p1_last_q;
  logic [3*ltfe_pkg::CHAN_W-1:0]    rgb;

  logic                             out_valid_q;
  logic [ltfe_pkg::CHAN_W-1:0]      out_chan_q [3];
  logic [ltfe_pkg::CHAN_W-1:0]      out_chan_d [3];
  logic [ltfe_pkg::IDX_W-1:0]       out_index_q;
  logic                             out_last_q;
  logic [ltfe_pkg::FULL_W-1:0]      full [3];
  logic [ltfe_pkg::FULL_W-ltfe_pkg::DIV_SHIFT-1:0] quot [3];

  assign adv_o = !out_valid_q || m_ready_i;
  assign rgb   = ltfe_pkg::palette_rgb(req_i.color);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      p1_prod_d[c] = ltfe_pkg::PROD_W'(rgb[(2-c)*ltfe_pkg::CHAN_W +: ltfe_pkg::CHAN_W])
                   * ltfe_pkg::PROD_W'(req_i.level);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      full[c] = ltfe_pkg::FULL_W'(p1_prod_q[c]) * ltfe_pkg::FULL_W'(ltfe_pkg::DIV_MUL);
      quot[c] = full[c][ltfe_pkg::FULL_W-1:ltfe_pkg::DIV_SHIFT];
      if (quot[c] > (ltfe_pkg::FULL_W-ltfe_pkg::DIV_SHIFT)'(255)) begin
        out_chan_d[c] = '1;
      end else begin
        out_chan_d[c] = quot[c][ltfe_pkg::CHAN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      p1_valid_q  <= req_valid_i;
      out_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      p1_prod_q   <= p1_prod_d;
      p1_index_q  <= req_i.index;
      p1_last_q   <= req_i.last;
      out_chan_q  <= out_chan_d;
      out_index_q <= p1_index_q;
      out_last_q  <= p1_last_q;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_last_o  = out_last_q;
  assign m_data_o  = {4'b0, out_chan_q[2], out_chan_q[1], out_chan_q[0], out_index_q};

endmodule

@@ sv/ltfe_checker.sv @@
`include "led_twinkle_fade_engine_defines.svh"

module ltfe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  localparam logic [ltfe_pkg::IDX_W-1:0] LAST_IDX = ltfe_pkg::IDX_W'(ltfe_pkg::CELL_COUNT - 1);

  logic [ltfe_pkg::IDX_W-1:0] exp_idx_q;

  // Pixels leave in strip order, starting over after each frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= '0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      exp_idx_q <= (exp_idx_q == LAST_IDX) ? '0 : exp_idx_q + ltfe_pkg::IDX_W'(1);
    end
  end

  `LTFE_ASSERT_NEXT(a_out_stall_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output changed while stalled")
  `LTFE_ASSERT_IMPL(a_last_on_final, clk_i, rst_ni, m_axis_tvalid, m_axis_tlast == (m_axis_tdata[ltfe_pkg::IDX_W-1:0] == LAST_IDX), "frame end flag on wrong pixel")
  `LTFE_ASSERT_IMPL(a_pixel_order, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[ltfe_pkg::IDX_W-1:0] == exp_idx_q, "pixel index out of order")
  `LTFE_ASSERT_NEXT(a_one_request, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while a frame is in progress")

endmodule

bind led_twinkle_fade_engine ltfe_checker u_ltfe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
